/* hdl/silu_pkg.sv */
`default_nettype none
package silu_pkg;

	localparam int DATA_WIDTH    = 16;
	localparam int SIG_TAB_DEPTH = 256;
	localparam int FRAC_BITS     = DATA_WIDTH - 4;

	// table addressing: top bits of the offset input pick the segment, the rest interpolate
	localparam int TAB_BITS = $clog2(SIG_TAB_DEPTH);
	localparam int TAB_AW   = TAB_BITS + 1;
	localparam int INTERP_W = DATA_WIDTH - TAB_BITS;

	// sigmoid in unsigned Q0.16, one extra bit so that 1.0 fits
	localparam int SIG_W = 17;
	localparam int TAB_W = SIG_W;
	localparam logic [SIG_W-1:0] SIG_ONE = SIG_W'(1) << 16;

	localparam int PROD_W  = TAB_W + INTERP_W + 1;
	localparam int SUM_W   = PROD_W + 1;
	localparam int SP_W    = 2 * SIG_W;
	localparam int XSP_W   = DATA_WIDTH + SP_W + 1;
	localparam int GRAD_SH = FRAC_BITS + 16;
	localparam int G_W     = SIG_W + 3;
	localparam int M_W     = DATA_WIDTH + G_W;
	localparam int OUT_SH  = 16;

	// registered stages from input transfer to output register
	localparam int PIPE_DEPTH = 8;

	localparam logic FUNC_FWD = 1'b0;
	localparam logic FUNC_BWD = 1'b1;

	typedef logic [SIG_TAB_DEPTH:0][TAB_W-1:0] sig_tab_t;

	localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
	localparam logic [63:0] EXP_NEG1_Q30 = 64'd395007542;

	// unsigned quotient by shift and subtract, evaluated at elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-num/SIG_TAB_DEPTH) in Q30: Taylor series on the fraction, then exp(-1) per unit
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] num);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] f;
		logic [63:0] term;
		logic [63:0] sum;
		n = num / SIG_TAB_DEPTH;
		r = num % SIG_TAB_DEPTH;
		f = (r << 30) / SIG_TAB_DEPTH;
		term = Q30_ONE;
		sum = Q30_ONE;
		for (int i = 1; i <= 16; i++) begin
			term = udiv64((term * f) >> 30, 64'(i));
			if (i % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		for (int j = 0; j < 64; j++) begin
			if (64'(j) < n) begin
				sum = (sum * EXP_NEG1_Q30 + (Q30_ONE >> 1)) >> 30;
			end
		end
		return sum;
	endfunction

	function automatic sig_tab_t sig_tab_init();
		sig_tab_t    tab;
		longint      d;
		logic [63:0] num;
		logic [63:0] e;
		logic [63:0] q;
		for (int k = 0; k <= SIG_TAB_DEPTH; k++) begin
			d = longint'(16 * k) - longint'(8 * SIG_TAB_DEPTH);
			num = (d < 0) ? 64'(-d) : 64'(d);
			e = exp_neg_q30(num);
			q = Q30_ONE + e;
			if (d >= 0) begin
				tab[k] = TAB_W'(udiv64((64'd1 << 46) + (q >> 1), q));
			end else begin
				tab[k] = TAB_W'(udiv64((e << 16) + (q >> 1), q));
			end
		end
		return tab;
	endfunction

endpackage
`default_nettype wire

/* hdl/silu_activation_core.sv */
// Pipeline: an input transfer passes through eight register stages, stage 1 to the
// output register, before its result shows on out_valid.
// Throughput: one item per cycle while the output does not stall; the sigmoid ROM has two registered read ports,
// so both interpolation points are fetched in the same cycle.
// Stalls pass back combinationally through the stage enables, so empty stages still fill while out_ready is low.
// Reset (arst_n low, asynchronous): all stage valid bits clear, no result is pending;
// the datapath registers are not reset.
`default_nettype none
module silu_activation_core import silu_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         func,
	input  wire logic signed [DATA_WIDTH-1:0] x_value,
	input  wire logic signed [DATA_WIDTH-1:0] upstream_grad,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0]      result_value,
	output logic                              saturated
);

	// sigmoid samples at -8 + 16k/DEPTH, Q0.16, built at elaboration
	localparam sig_tab_t SigRom = sig_tab_init();

	localparam logic [SUM_W-1:0]           InterpHalf = SUM_W'(1) << (INTERP_W - 1);
	localparam logic signed [XSP_W-1:0]    XspHalf    = XSP_W'(1) << (GRAD_SH - 1);
	localparam logic signed [M_W-1:0]      OutHalf    = M_W'(1) << (OUT_SH - 1);
	localparam logic signed [M_W-1:0]      OutMax     =
		$signed({{(M_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}});
	localparam logic signed [M_W-1:0]      OutMin     =
		$signed({{(M_W - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}});

	// stage valid bits and per-stage load enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, out_vld_q;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	// a stage loads when it is empty or its content moves on in the same cycle
	assign en8 = !out_vld_q || out_ready;
	assign en7 = !vld_s7 || en8;
	assign en6 = !vld_s6 || en7;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en1) vld_s1    <= in_valid;
			if (en2) vld_s2    <= vld_s1;
			if (en3) vld_s3    <= vld_s2;
			if (en4) vld_s4    <= vld_s3;
			if (en5) vld_s5    <= vld_s4;
			if (en6) vld_s6    <= vld_s5;
			if (en7) vld_s7    <= vld_s6;
			if (en8) out_vld_q <= vld_s7;
		end
	end

	// Stage 1: offset x by half the range; top bits address the ROM, low bits interpolate.
	logic [DATA_WIDTH-1:0] u_off;
	logic [TAB_AW-1:0]     addr_lo, addr_hi;

	assign u_off   = {~x_value[DATA_WIDTH-1], x_value[DATA_WIDTH-2:0]};
	assign addr_lo = {1'b0, u_off[DATA_WIDTH-1 -: TAB_BITS]};
	assign addr_hi = addr_lo + TAB_AW'(1);

	logic [TAB_W-1:0]             t0_s1, t1_s1;
	logic [INTERP_W-1:0]          f_s1;
	logic signed [DATA_WIDTH-1:0] x_s1, gy_s1;
	logic                         func_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			t0_s1   <= SigRom[addr_lo];
			t1_s1   <= SigRom[addr_hi];
			f_s1    <= u_off[INTERP_W-1:0];
			x_s1    <= x_value;
			gy_s1   <= upstream_grad;
			func_s1 <= func;
		end
	end

	// Stage 2: weight both table points.
	logic [INTERP_W:0] w_lo;
	assign w_lo = (INTERP_W + 1)'(1) << INTERP_W;

	logic [PROD_W-1:0]            p0_s2, p1_s2;
	logic signed [DATA_WIDTH-1:0] x_s2, gy_s2;
	logic                         func_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			p0_s2   <= PROD_W'(t0_s1) * PROD_W'(w_lo - (INTERP_W + 1)'(f_s1));
			p1_s2   <= PROD_W'(t1_s1) * PROD_W'(f_s1);
			x_s2    <= x_s1;
			gy_s2   <= gy_s1;
			func_s2 <= func_s1;
		end
	end

	// Stage 3: sum, round half up, drop the interpolation fraction.
	logic [SUM_W-1:0] interp_sum;
	assign interp_sum = SUM_W'(p0_s2) + SUM_W'(p1_s2) + InterpHalf;

	logic [SIG_W-1:0]             s_s3;
	logic signed [DATA_WIDTH-1:0] x_s3, gy_s3;
	logic                         func_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			s_s3    <= interp_sum[INTERP_W +: SIG_W];
			x_s3    <= x_s2;
			gy_s3   <= gy_s2;
			func_s3 <= func_s2;
		end
	end

	// Stage 4: s*(1-s) in Q0.32.
	logic [SP_W-1:0]              sp_s4;
	logic [SIG_W-1:0]             s_s4;
	logic signed [DATA_WIDTH-1:0] x_s4, gy_s4;
	logic                         func_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			sp_s4   <= SP_W'(s_s3) * SP_W'(SIG_ONE - s_s3);
			s_s4    <= s_s3;
			x_s4    <= x_s3;
			gy_s4   <= gy_s3;
			func_s4 <= func_s3;
		end
	end

	// Stage 5: x*s*(1-s).
	logic signed [XSP_W-1:0]      xsp_s5;
	logic [SIG_W-1:0]             s_s5;
	logic signed [DATA_WIDTH-1:0] x_s5, gy_s5;
	logic                         func_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			xsp_s5  <= $signed(XSP_W'(x_s4)) * $signed(XSP_W'({1'b0, sp_s4}));
			s_s5    <= s_s4;
			x_s5    <= x_s4;
			gy_s5   <= gy_s4;
			func_s5 <= func_s4;
		end
	end

	// Stage 6: derivative g = s + x*s*(1-s), back to Q.16.
	logic signed [XSP_W-1:0] xsp_rnd;
	assign xsp_rnd = (xsp_s5 + XspHalf) >>> GRAD_SH;

	logic signed [G_W-1:0]        g_s6;
	logic [SIG_W-1:0]             s_s6;
	logic signed [DATA_WIDTH-1:0] x_s6, gy_s6;
	logic                         func_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			g_s6    <= G_W'(xsp_rnd) + $signed(G_W'({1'b0, s_s5}));
			s_s6    <= s_s5;
			x_s6    <= x_s5;
			gy_s6   <= gy_s5;
			func_s6 <= func_s5;
		end
	end

	// Stage 7: shared output multiplier, x*s forward or gy*g backward.
	logic signed [DATA_WIDTH-1:0] mul_a;
	logic signed [G_W-1:0]        mul_b;

	always_comb begin
		case (func_s6)
			FUNC_BWD: begin
				mul_a = gy_s6;
				mul_b = g_s6;
			end
			default: begin
				mul_a = x_s6;
				mul_b = $signed(G_W'({1'b0, s_s6}));
			end
		endcase
	end

	logic signed [M_W-1:0] m_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			m_s7 <= $signed(M_W'(mul_a)) * $signed(M_W'(mul_b));
		end
	end

	// Stage 8: round to Q4.12, saturate, hold in the output register.
	logic signed [M_W-1:0] y_rnd;
	logic                  sat_hi, sat_lo;

	assign y_rnd  = (m_s7 + OutHalf) >>> OUT_SH;
	assign sat_hi = y_rnd > OutMax;
	assign sat_lo = y_rnd < OutMin;

	logic signed [DATA_WIDTH-1:0] result_q;
	logic                         sat_q;

	always_ff @(posedge clk) begin
		if (en8) begin
			if (sat_hi) begin
				result_q <= OutMax[DATA_WIDTH-1:0];
			end else if (sat_lo) begin
				result_q <= OutMin[DATA_WIDTH-1:0];
			end else begin
				result_q <= y_rnd[DATA_WIDTH-1:0];
			end
			sat_q <= sat_hi || sat_lo;
		end
	end

	assign out_valid    = out_vld_q;
	assign result_value = result_q;
	assign saturated    = sat_q;

endmodule
`default_nettype wire

/* hdl/silu_chk.sv */
`default_nettype none
module silu_chk import silu_pkg::*; (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         func,
	input wire logic signed [DATA_WIDTH-1:0] x_value,
	input wire logic signed [DATA_WIDTH-1:0] upstream_grad,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic signed [DATA_WIDTH-1:0] result_value,
	input wire logic                         saturated
);

	localparam int CntW = $clog2(PIPE_DEPTH + 1);

	logic [CntW-1:0] occ_q;
	logic            in_xfer, out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// track items in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			occ_q <= occ_q + CntW'(1);
		end else if (out_xfer && !in_xfer) begin
			occ_q <= occ_q - CntW'(1);
		end
	end

	logic unused_ok;
	assign unused_ok = func ^ (^x_value) ^ (^upstream_grad);

	// reset clears the output stage asynchronously, so no result shows once reset has been sampled low
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result shown during reset");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occ_q != '0))
		else $error("result without a pending input transfer");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CntW'(PIPE_DEPTH) || unused_ok != unused_ok)
		else $error("more items in flight than pipeline stages");

	a_sat_clamps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
		(result_value == $signed({1'b0, {(DATA_WIDTH - 1){1'b1}}})) ||
		(result_value == $signed({1'b1, {(DATA_WIDTH - 1){1'b0}}})))
		else $error("saturation flag set on an unclamped result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(result_value) && $stable(saturated)))
		else $error("stalled result changed");

endmodule

bind silu_activation_core silu_chk u_silu_chk (.*);
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import silu_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int WATCHDOG_MAX  = 1000;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int DRAIN_CYCLES  = PIPE_DEPTH * 4;

	// fixed-point constants for building the sigmoid points (Q30)
	localparam longint unsigned ONE_Q30   = 64'd1 << 30;
	localparam longint unsigned INV_E_Q30 = 64'd395007542;
	localparam longint unsigned SPAN      = 64'd1 << DATA_WIDTH;

	typedef struct {
		logic                         func;
		logic signed [DATA_WIDTH-1:0] x;
		logic signed [DATA_WIDTH-1:0] gy;
	} silu_item_t;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] value;
		logic                         sat;
	} silu_result_t;

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         in_valid      = 1'b0;
	logic                         in_ready;
	logic                         func          = FUNC_FWD;
	logic signed [DATA_WIDTH-1:0] x_value       = '0;
	logic signed [DATA_WIDTH-1:0] upstream_grad = '0;
	logic                         out_valid;
	logic                         out_ready     = 1'b0;
	logic signed [DATA_WIDTH-1:0] result_value;
	logic                         saturated;

	// sigmoid sample points in unsigned Q0.16, one past the last segment
	longint unsigned sig_rom [0:SIG_TAB_DEPTH];

	silu_item_t   pending_items [$];
	silu_result_t expected_results [$];

	int errors       = 0;
	int send_gap     = 0;
	int send_quiet   = 0;
	int stall_left   = 0;
	int stall_quiet  = 0;
	int idle_cycles  = 0;

	silu_activation_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.x_value      (x_value),
		.upstream_grad(upstream_grad),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.saturated    (saturated)
	);

	always #CLK_HALF clk = ~clk;

	// round v / 2^sh to nearest, ties toward +infinity
	function automatic longint round_shift(longint v, int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// expected SiLU or SiLU-gradient result for one element
	function automatic silu_result_t silu_predict(silu_item_t it);
		silu_result_t    res;
		longint          x, gy, s, s1, g, y;
		longint unsigned u, pos, seg, frac;
		x    = it.x;
		gy   = it.gy;
		u    = longint'(x + (SPAN >> 1));
		pos  = u * SIG_TAB_DEPTH;
		seg  = pos >> DATA_WIDTH;
		frac = pos & (SPAN - 1);
		s    = (sig_rom[seg] * (SPAN - frac) + sig_rom[seg + 1] * frac + (SPAN >> 1)) >> DATA_WIDTH;
		if (it.func == FUNC_FWD) begin
			y = round_shift(x * s, 16);
		end else begin
			s1 = s * (65536 - s);
			g  = s + round_shift(x * s1, FRAC_BITS + 16);
			y  = round_shift(gy * g, 16);
		end
		res.sat = 1'b0;
		if (y > 32767) begin
			y       = 32767;
			res.sat = 1'b1;
		end
		if (y < -32768) begin
			y       = -32768;
			res.sat = 1'b1;
		end
		res.value = DATA_WIDTH'(y);
		return res;
	endfunction

	task automatic add_item(logic f, logic signed [DATA_WIDTH-1:0] xv,
	                        logic signed [DATA_WIDTH-1:0] gv);
		silu_item_t it;
		it.func = f;
		it.x    = xv;
		it.gy   = gv;
		pending_items.push_back(it);
	endtask

	// Driver: present one item at a time, hold it until the transfer, then idle at random.
	always @(posedge clk) begin
		silu_item_t it;
		if (arst_n) begin
			// predict on the transfer, from the payload that was on the ports
			if (in_valid && in_ready) begin
				it.func = func;
				it.x    = x_value;
				it.gy   = upstream_grad;
				expected_results.push_back(silu_predict(it));
				if (send_quiet > 0) begin
					send_quiet--;
					send_gap = 0;
				end else begin
					send_gap = pick_idle_len();
					if ($urandom_range(0, 99) == 0) send_quiet = $urandom_range(50, 200);
				end
			end
			// hold the payload while the core stalls the input
			if (!(in_valid && !in_ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					it = pending_items.pop_front();
					func          <= it.func;
					x_value       <= it.x;
					upstream_grad <= it.gy;
					in_valid      <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer against the oldest prediction, then stall at random.
	always @(posedge clk) begin
		silu_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: result_value %0d saturated %0b",
					         $time, result_value, saturated);
				end else begin
					want = expected_results.pop_front();
					if (result_value !== want.value) begin
						errors++;
						$display("%0t: result_value expected %0d actual %0d",
						         $time, want.value, result_value);
					end
					if (saturated !== want.sat) begin
						errors++;
						$display("%0t: saturated expected %0b actual %0b",
						         $time, want.sat, saturated);
					end
				end
			end
			// drop ready for a random stretch now and then, keep it high in quiet spells
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (stall_quiet > 0) begin
				stall_quiet--;
				out_ready <= 1'b1;
			end else begin
				stall_left = pick_idle_len();
				if ($urandom_range(0, 99) == 0) stall_quiet = $urandom_range(50, 200);
				out_ready <= (stall_left == 0);
			end
		end
	end

	// Watchdog: end the run if no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_MAX) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_MAX);
				$display("[silu_activation_core] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		longint unsigned num, whole, frac, term, acc, q;
		int              d;
		logic signed [DATA_WIDTH-1:0] xr, gr;

		// build the sigmoid points: exp(-|x|) from a Taylor series on the fraction,
		// then one factor of exp(-1) per whole unit
		for (int k = 0; k <= SIG_TAB_DEPTH; k++) begin
			d     = 16 * k - 8 * SIG_TAB_DEPTH;
			num   = longint'((d < 0) ? -d : d);
			whole = num / SIG_TAB_DEPTH;
			frac  = ((num % SIG_TAB_DEPTH) << 30) / SIG_TAB_DEPTH;
			term  = ONE_Q30;
			acc   = ONE_Q30;
			for (int i = 1; i <= 16; i++) begin
				term = ((term * frac) >> 30) / longint'(i);
				if (i % 2 == 1) acc = acc - term;
				else acc = acc + term;
			end
			for (longint unsigned j = 0; j < whole; j++) begin
				acc = (acc * INV_E_Q30 + (ONE_Q30 >> 1)) >> 30;
			end
			q = ONE_Q30 + acc;
			if (d >= 0) sig_rom[k] = ((64'd1 << 46) + q / 2) / q;
			else sig_rom[k] = ((acc << 16) + q / 2) / q;
		end

		// directed: input extremes, sign edges, segment ends, and forward mode with a
		// gradient that must be ignored
		add_item(FUNC_FWD, -16'sd32768, 16'sd32767);
		add_item(FUNC_FWD, 16'sd32767, -16'sd32768);
		add_item(FUNC_FWD, 16'sd0, 16'sd0);
		add_item(FUNC_FWD, -16'sd1, 16'sd12345);
		add_item(FUNC_FWD, 16'sd1, -16'sd1);
		add_item(FUNC_FWD, 16'sd4096, 16'sd0);
		add_item(FUNC_FWD, -16'sd4096, 16'sd0);
		add_item(FUNC_FWD, 16'sh7F00, 16'sd0);
		add_item(FUNC_FWD, -16'sd32513, 16'sd0);
		add_item(FUNC_FWD, 16'sh00FF, 16'sd0);
		add_item(FUNC_BWD, 16'sd0, 16'sd32767);
		add_item(FUNC_BWD, 16'sd0, -16'sd32768);
		add_item(FUNC_BWD, 16'sd32767, 16'sd32767);
		add_item(FUNC_BWD, -16'sd32768, -16'sd32768);
		add_item(FUNC_BWD, -16'sd32768, 16'sd32767);
		add_item(FUNC_BWD, 16'sd32767, -16'sd32768);
		// gradient peaks above one near x = 2.4, so a full-scale gy saturates both ways
		add_item(FUNC_BWD, 16'sd9830, 16'sd32767);
		add_item(FUNC_BWD, 16'sd9830, -16'sd32768);
		add_item(FUNC_BWD, 16'sd12288, -16'sd32767);
		add_item(FUNC_BWD, 16'sd1, 16'sd1);
		add_item(FUNC_BWD, -16'sd1, -16'sd1);
		add_item(FUNC_BWD, -16'sd9830, 16'sd32767);

		// random: mix of full-range values, the steep middle, and segment ends
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: xr = DATA_WIDTH'($urandom);
				5, 6, 7:       xr = DATA_WIDTH'($urandom_range(0, 32767)) - 16'sd16384;
				default:       xr = {8'($urandom), ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
			endcase
			case ($urandom_range(0, 3))
				0, 1:    gr = DATA_WIDTH'($urandom);
				2:       gr = DATA_WIDTH'($urandom_range(0, 511)) - 16'sd256;
				default: gr = $urandom_range(0, 1) ? 16'sd32767 - DATA_WIDTH'($urandom_range(0, 2000))
				                                   : -16'sd32768 + DATA_WIDTH'($urandom_range(0, 2000));
			endcase
			add_item($urandom_range(0, 1) ? FUNC_BWD : FUNC_FWD, xr, gr);
		end

		// hold reset, then release it at a clock edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// advance until every item has gone in and every result has come back
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(negedge clk);
		// let any stray result surface
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0) begin
			$display("[silu_activation_core] OK");
		end else begin
			$display("[silu_activation_core] ERROR");
		end
		$finish;
	end

endmodule
